>>> src/hsvh_pkg.sv
// Shared types, constants and state encodings of the hue-saturation histogram.
package hsvh_pkg;

    localparam int DEF_BINS       = 256;
    localparam int DEF_COUNT_BITS = 24;
    localparam int SUM_BITS       = 32;
    localparam int CHAN_BITS      = 8;
    localparam int FRONT_DIV_BITS = 20;
    localparam int BACK_DIV_BITS  = 32;

    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [CHAN_BITS-1:0] hue;
        logic [CHAN_BITS-1:0] sat;
        logic [CHAN_BITS-1:0] value;
    } work_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SAT,
        FR_HUE,
        FR_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FETCH,
        BK_MEAN,
        BK_PROD,
        BK_DIV_W,
        BK_DIV_Q,
        BK_DIV_T,
        BK_DONE
    } back_state_t;

endpackage

>>> src/hsvh_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module hsvh_div #(
    parameter int WIDTH = hsvh_pkg::BACK_DIV_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH:0]   rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] den_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    assign shifted = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= trial[WIDTH] ? shifted : trial;
            quo_reg <= {quo_reg[WIDTH-2:0], ~trial[WIDTH]};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/hsvh_ram.sv
// Generic single-port RAM with registered read data.
module hsvh_ram #(
    parameter int WIDTH = hsvh_pkg::SUM_BITS,
    parameter int DEPTH = hsvh_pkg::DEF_BINS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/hsvh_front.sv
// Front end: accepts words, converts pixels to hue and saturation bins.
module hsvh_front #(
    parameter int BINS_PER_AXIS = hsvh_pkg::DEF_BINS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           req_type,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] red,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] green,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] blue,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] hue_bin,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] sat_bin,
    output logic                           work_valid,
    input  logic                           work_ready,
    output hsvh_pkg::work_t                work_word
);

    localparam int M  = BINS_PER_AXIS - 1;
    localparam int DW = hsvh_pkg::FRONT_DIV_BITS;

    hsvh_pkg::front_state_t state_reg, state_next;
    logic [7:0]      red_reg, green_reg, blue_reg, mx_reg, d_reg;
    hsvh_pkg::work_t word_reg;
    logic [7:0]      in_mx, in_mn, in_d;
    logic [11:0]     num;
    logic            accept;
    logic            div_start, div_busy, div_done;
    logic [DW-1:0]   div_dividend, div_divisor, div_quotient;

    always_comb
    begin
        in_mx = red;
        in_mn = red;
        if (green > in_mx) in_mx = green;
        if (blue > in_mx) in_mx = blue;
        if (green < in_mn) in_mn = green;
        if (blue < in_mn) in_mn = blue;
        in_d = in_mx - in_mn;
    end

    always_comb
    begin
        if (red_reg == mx_reg)
        begin
            num = 12'(green_reg) - 12'(blue_reg);
            if (green_reg < blue_reg) num = num + 12'(d_reg) * 12'd6;
        end
        else if (green_reg == mx_reg)
        begin
            num = 12'(d_reg) * 12'd2 + 12'(blue_reg) - 12'(red_reg);
        end
        else
        begin
            num = 12'(d_reg) * 12'd4 + 12'(red_reg) - 12'(green_reg);
        end
    end

    assign accept = push && (state_reg == hsvh_pkg::FR_IDLE);

    always_comb
    begin
        if (state_reg == hsvh_pkg::FR_IDLE)
        begin
            div_dividend = DW'(M) * DW'(in_d);
            div_divisor  = DW'(in_mx);
        end
        else
        begin
            div_dividend = DW'(M) * DW'(num);
            div_divisor  = DW'(d_reg) * DW'(6);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hsvh_pkg::FR_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == hsvh_pkg::REQ_READ || in_d == 8'd0)
                        state_next = hsvh_pkg::FR_PUSH;
                    else
                        state_next = hsvh_pkg::FR_SAT;
                end
            end
            hsvh_pkg::FR_SAT:  if (div_done) state_next = hsvh_pkg::FR_HUE;
            hsvh_pkg::FR_HUE:  if (div_done) state_next = hsvh_pkg::FR_PUSH;
            hsvh_pkg::FR_PUSH: if (work_ready) state_next = hsvh_pkg::FR_IDLE;
            default:           state_next = hsvh_pkg::FR_IDLE;
        endcase
    end

    always_comb
    begin
        full       = (state_reg != hsvh_pkg::FR_IDLE);
        work_valid = (state_reg == hsvh_pkg::FR_PUSH);
        div_start  = 1'b0;
        case (state_reg)
            hsvh_pkg::FR_IDLE:
                div_start = accept && req_type == hsvh_pkg::REQ_ACCUM && in_d != 8'd0;
            hsvh_pkg::FR_SAT:
                div_start = div_done;
            default:
                div_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hsvh_pkg::FR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            mx_reg    <= in_mx;
            d_reg     <= in_d;
            word_reg.req_type <= req_type;
            word_reg.value    <= in_mx;
            if (req_type == hsvh_pkg::REQ_READ)
            begin
                word_reg.hue <= hue_bin;
                word_reg.sat <= sat_bin;
            end
            else
            begin
                word_reg.hue <= '0;
                word_reg.sat <= '0;
            end
        end
        else if (state_reg == hsvh_pkg::FR_SAT && div_done)
        begin
            word_reg.sat <= div_quotient[7:0];
        end
        else if (state_reg == hsvh_pkg::FR_HUE && div_done)
        begin
            word_reg.hue <= div_quotient[7:0];
        end
    end

    assign work_word = word_reg;

    hsvh_div #(.WIDTH(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("Front divider started while busy.");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hsvh_pkg::FR_PUSH |-> full && work_valid)
        else $error("Front offered a word while accepting input.");

    a_sat_to_hue: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hsvh_pkg::FR_SAT && div_done |=> div_busy)
        else $error("Hue division did not start after saturation.");

endmodule

>>> src/hsvh_back.sv
// Back end: bin store update, read-and-clear, mean and colour reconstruction.
module hsvh_back #(
    parameter int BINS_PER_AXIS = hsvh_pkg::DEF_BINS,
    parameter int COUNT_BITS    = hsvh_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           work_valid,
    output logic                           work_ready,
    input  hsvh_pkg::work_t                work_word,
    output logic                           empty,
    input  logic                           pop,
    output logic [hsvh_pkg::CHAN_BITS-1:0] out_red,
    output logic [hsvh_pkg::CHAN_BITS-1:0] out_green,
    output logic [hsvh_pkg::CHAN_BITS-1:0] out_blue,
    output logic                           occupied
);

    localparam int M     = BINS_PER_AXIS - 1;
    localparam int MM    = M * M;
    localparam int NBINS = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int AW    = $clog2(NBINS);
    localparam int SB    = hsvh_pkg::SUM_BITS;
    localparam int RW    = SB + COUNT_BITS;
    localparam int BW    = hsvh_pkg::BACK_DIV_BITS;
    localparam int KW    = 16 + $clog2(M);
    localparam int KQ    = 27 + $clog2(MM);
    localparam longint unsigned RCP_W = ((64'd1 << KW) + 64'(M) - 64'd1) / 64'(M);
    localparam longint unsigned RCP_Q = ((64'd1 << KQ) + 64'(MM) - 64'd1) / 64'(MM);

    hsvh_pkg::back_state_t state_reg, state_next;
    logic [AW:0]     clr_reg, clr_next;
    logic            out_valid_reg, out_valid_next;
    hsvh_pkg::work_t word_reg;
    logic [AW-1:0]   idx_reg;
    logic [2:0]      i_reg;
    logic [7:0]      wnum_reg, v_reg, w_reg, q_reg;
    logic [19:0]     qnum_reg, tnum_reg;
    logic [15:0]     pw_reg;
    logic [BW-1:0]   pq_reg, pt_reg;
    logic [7:0]      col_red_reg, col_green_reg, col_blue_reg;
    logic            col_occ_reg;
    logic [7:0]      out_red_reg, out_green_reg, out_blue_reg;
    logic            out_occ_reg;

    logic            in_range;
    logic [AW-1:0]   head_idx;
    logic [10:0]     hsix, f_val;
    logic [2:0]      i_raw, i_sel;
    logic [19:0]     sf, sm;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [RW-1:0]   ram_wdata, ram_rdata;
    logic [SB-1:0]   rd_sum;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [SB:0]     sum_add;
    logic            div_start, div_busy, div_done;
    logic [BW-1:0]   div_dividend, div_divisor, div_quotient;
    logic [63:0]     w_prod, q_prod, t_prod;
    logic [7:0]      w_val, q_val, t_val, mean_val;
    logic            result_load;

    assign in_range = (9'(work_word.hue) < 9'(BINS_PER_AXIS))
                   && (9'(work_word.sat) < 9'(BINS_PER_AXIS));
    assign head_idx = AW'(int'(work_word.hue) * BINS_PER_AXIS + int'(work_word.sat));

    always_comb
    begin
        hsix  = 11'(work_word.hue) * 11'd6;
        i_raw = 3'd0;
        for (int k = 1; k <= 6; k++)
        begin
            if (hsix >= 11'(k * M)) i_raw = 3'(k);
        end
        i_sel = (i_raw == 3'd6) ? 3'd0 : i_raw;
        f_val = hsix - 11'(M) * 11'(i_sel);
        sf    = 20'(work_word.sat) * 20'(f_val);
        sm    = 20'(work_word.sat) * 20'(M);
    end

    assign rd_sum  = ram_rdata[RW-1:COUNT_BITS];
    assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
    assign sum_add = {1'b0, rd_sum} + (SB + 1)'(word_reg.value);
    assign mean_val = (div_quotient > BW'(255)) ? 8'd255 : div_quotient[7:0];

    // Divisions by the constants M and M*M use exact reciprocal multiplication.
    assign w_prod = 64'(pw_reg) * RCP_W;
    assign q_prod = 64'(pq_reg) * RCP_Q;
    assign t_prod = 64'(pt_reg) * RCP_Q;
    assign w_val  = 8'(w_prod >> KW);
    assign q_val  = 8'(q_prod >> KQ);
    assign t_val  = 8'(t_prod >> KQ);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = head_idx;
        ram_wdata = '0;
        case (state_reg)
            hsvh_pkg::BK_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg[AW-1:0];
            end
            hsvh_pkg::BK_FETCH:
            begin
                ram_we   = 1'b1;
                ram_addr = idx_reg;
                if (word_reg.req_type == hsvh_pkg::REQ_ACCUM)
                begin
                    ram_wdata[RW-1:COUNT_BITS] = sum_add[SB] ? '1 : sum_add[SB-1:0];
                    ram_wdata[COUNT_BITS-1:0]  = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
                end
            end
            default:
            begin
                ram_we   = 1'b0;
                ram_addr = head_idx;
            end
        endcase
    end

    assign div_dividend = BW'(rd_sum);
    assign div_divisor  = BW'(rd_cnt);
    assign div_start    = (state_reg == hsvh_pkg::BK_FETCH)
                       && (word_reg.req_type == hsvh_pkg::REQ_READ) && (rd_cnt != '0);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            hsvh_pkg::BK_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW + 1)'(NBINS - 1)) state_next = hsvh_pkg::BK_IDLE;
            end
            hsvh_pkg::BK_IDLE:
            begin
                if (work_valid)
                begin
                    if (work_word.req_type == hsvh_pkg::REQ_ACCUM || in_range)
                        state_next = hsvh_pkg::BK_FETCH;
                    else
                        state_next = hsvh_pkg::BK_DONE;
                end
            end
            hsvh_pkg::BK_FETCH:
            begin
                if (word_reg.req_type == hsvh_pkg::REQ_ACCUM)
                    state_next = hsvh_pkg::BK_IDLE;
                else if (rd_cnt == '0)
                    state_next = hsvh_pkg::BK_DONE;
                else
                    state_next = hsvh_pkg::BK_MEAN;
            end
            hsvh_pkg::BK_MEAN:  if (div_done) state_next = hsvh_pkg::BK_PROD;
            hsvh_pkg::BK_PROD:  state_next = hsvh_pkg::BK_DIV_W;
            hsvh_pkg::BK_DIV_W: state_next = hsvh_pkg::BK_DIV_Q;
            hsvh_pkg::BK_DIV_Q: state_next = hsvh_pkg::BK_DIV_T;
            hsvh_pkg::BK_DIV_T: state_next = hsvh_pkg::BK_DONE;
            hsvh_pkg::BK_DONE:  if (!out_valid_reg || pop) state_next = hsvh_pkg::BK_IDLE;
            default:            state_next = hsvh_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        work_ready     = (state_reg == hsvh_pkg::BK_IDLE);
        result_load    = (state_reg == hsvh_pkg::BK_DONE) && (!out_valid_reg || pop);
        out_valid_next = out_valid_reg;
        if (result_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hsvh_pkg::BK_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            hsvh_pkg::BK_IDLE:
            begin
                word_reg      <= work_word;
                idx_reg       <= head_idx;
                i_reg         <= i_sel;
                wnum_reg      <= 8'(M) - work_word.sat;
                qnum_reg      <= 20'(MM) - sf;
                tnum_reg      <= 20'(MM) - sm + sf;
                col_red_reg   <= 8'd255;
                col_green_reg <= 8'd255;
                col_blue_reg  <= 8'd255;
                col_occ_reg   <= 1'b0;
            end
            hsvh_pkg::BK_MEAN:
            begin
                if (div_done) v_reg <= mean_val;
            end
            hsvh_pkg::BK_PROD:
            begin
                pw_reg <= 16'(v_reg) * 16'(wnum_reg);
                pq_reg <= BW'(v_reg) * BW'(qnum_reg);
                pt_reg <= BW'(v_reg) * BW'(tnum_reg);
            end
            hsvh_pkg::BK_DIV_W:
            begin
                w_reg <= w_val;
            end
            hsvh_pkg::BK_DIV_Q:
            begin
                q_reg <= q_val;
            end
            hsvh_pkg::BK_DIV_T:
            begin
                col_occ_reg <= 1'b1;
                case (i_reg)
                    3'd0:
                    begin
                        col_red_reg <= v_reg; col_green_reg <= t_val; col_blue_reg <= w_reg;
                    end
                    3'd1:
                    begin
                        col_red_reg <= q_reg; col_green_reg <= v_reg; col_blue_reg <= w_reg;
                    end
                    3'd2:
                    begin
                        col_red_reg <= w_reg; col_green_reg <= v_reg; col_blue_reg <= t_val;
                    end
                    3'd3:
                    begin
                        col_red_reg <= w_reg; col_green_reg <= q_reg; col_blue_reg <= v_reg;
                    end
                    3'd4:
                    begin
                        col_red_reg <= t_val; col_green_reg <= w_reg; col_blue_reg <= v_reg;
                    end
                    default:
                    begin
                        col_red_reg <= v_reg; col_green_reg <= w_reg; col_blue_reg <= q_reg;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        if (result_load)
        begin
            out_red_reg   <= col_red_reg;
            out_green_reg <= col_green_reg;
            out_blue_reg  <= col_blue_reg;
            out_occ_reg   <= col_occ_reg;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign occupied  = out_occ_reg;

    hsvh_ram #(.WIDTH(RW), .DEPTH(NBINS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    hsvh_div #(.WIDTH(BW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hsvh_pkg::BK_CLEAR |-> !work_ready)
        else $error("Word taken during the clearing pass.");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("Back divider started while busy.");

    a_empty_bin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hsvh_pkg::BK_FETCH && word_reg.req_type == hsvh_pkg::REQ_READ
        && rd_cnt == '0 |=> state_reg == hsvh_pkg::BK_DONE && !col_occ_reg)
        else $error("Empty bin read did not return white.");

endmodule

>>> src/hue_sat_value_histogram_unit.sv
// Top level of the hue-by-saturation histogram with its front-to-back word queue.
//
// Input channel: drive push with a word; it is taken when full is low.
// req_type 0 adds the pixel red/green/blue to its hue-saturation bin;
// req_type 1 reads the bin named by hue_bin/sat_bin, returns its colour
// and clears it. Accumulate words produce no result.
// Result channel: a word waits on out_red/out_green/out_blue/occupied while
// empty is low and leaves at a clock edge with pop high.
// Work per word: the front runs two serial divisions of its bit-serial divider
// for a colored pixel and none for a grey pixel or a read. The back runs one
// serial division, for the mean, only on a read of an occupied bin; other
// words need none. A two-word queue lets the two halves overlap.
// After reset the back end sweeps the bin memory, one bin per cycle, and
// words queue up during that sweep.
// When the receiver stalls, the held result blocks the back end only once
// another result is ready; the front and queue keep taking words until full.
module hue_sat_value_histogram_unit #(
    parameter int BINS_PER_AXIS = hsvh_pkg::DEF_BINS,
    parameter int COUNT_BITS    = hsvh_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           req_type,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] red,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] green,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] blue,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] hue_bin,
    input  logic [hsvh_pkg::CHAN_BITS-1:0] sat_bin,
    output logic                           empty,
    input  logic                           pop,
    output logic [hsvh_pkg::CHAN_BITS-1:0] out_red,
    output logic [hsvh_pkg::CHAN_BITS-1:0] out_green,
    output logic [hsvh_pkg::CHAN_BITS-1:0] out_blue,
    output logic                           occupied
);

    logic            front_valid, q_ready;
    hsvh_pkg::work_t front_word;
    logic            back_ready, q_valid;
    hsvh_pkg::work_t q_entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            q_push, q_pop;

    assign q_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_push  = front_valid && q_ready;
    assign q_pop   = back_ready && q_valid;

    always_comb
    begin
        wr_ptr_next = q_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(q_push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push) q_entry_reg[wr_ptr_reg] <= front_word;
    end

    hsvh_front #(.BINS_PER_AXIS(BINS_PER_AXIS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hue_bin    (hue_bin),
        .sat_bin    (sat_bin),
        .work_valid (front_valid),
        .work_ready (q_ready),
        .work_word  (front_word)
    );

    hsvh_back #(.BINS_PER_AXIS(BINS_PER_AXIS), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (q_valid),
        .work_ready (back_ready),
        .work_word  (q_entry_reg[rd_ptr_reg]),
        .empty      (empty),
        .pop        (pop),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .occupied   (occupied)
    );

endmodule
